@@ sv/sprite_alpha_merge_pixel_top_macros.svh @@
// Assertion macros for the sprite alpha merge block.
// Bodies refer to clk and arst_n of the module that uses them.
`ifndef SPRITE_ALPHA_MERGE_PIXEL_TOP_MACROS_SVH
`define SPRITE_ALPHA_MERGE_PIXEL_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SAM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sam assertion failed");

// antecedent implies consequent in the next cycle
`define SAM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sam assertion failed");

`endif

@@ sv/sam_pkg.sv @@
// Shared types and constants for the sprite alpha merge block.
// No dependencies; used by the interfaces and every module.
package sam_pkg;

	localparam int PIX_W   = 32;
	localparam int CHAN_W  = 8;
	localparam int SHIFT_W = 5;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [2:0] REG_SRC_RED   = 3'd0;
	localparam logic [2:0] REG_SRC_GREEN = 3'd1;
	localparam logic [2:0] REG_SRC_BLUE  = 3'd2;
	localparam logic [2:0] REG_SRC_ALPHA = 3'd3;
	localparam logic [2:0] REG_DST_RED   = 3'd4;
	localparam logic [2:0] REG_DST_GREEN = 3'd5;
	localparam logic [2:0] REG_DST_BLUE  = 3'd6;
	localparam logic [2:0] REG_DST_ALPHA = 3'd7;

	localparam logic [SHIFT_W-1:0] RST_RED   = 5'd16;
	localparam logic [SHIFT_W-1:0] RST_GREEN = 5'd8;
	localparam logic [SHIFT_W-1:0] RST_BLUE  = 5'd0;
	localparam logic [SHIFT_W-1:0] RST_ALPHA = 5'd24;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

	typedef struct packed {
		logic [SHIFT_W-1:0] src_red;
		logic [SHIFT_W-1:0] src_green;
		logic [SHIFT_W-1:0] src_blue;
		logic [SHIFT_W-1:0] src_alpha;
		logic [SHIFT_W-1:0] dst_red;
		logic [SHIFT_W-1:0] dst_green;
		logic [SHIFT_W-1:0] dst_blue;
		logic [SHIFT_W-1:0] dst_alpha;
	} sam_cfg_t;

endpackage

@@ sv/sam_in_if.sv @@
// Input channel carrying one sprite pixel and the destination pixel under it.
// Depends on sam_pkg.
interface sam_in_if;
	import sam_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] sprite_pixel;
	logic [PIX_W-1:0] dest_pixel;

	modport source(output valid, sprite_pixel, dest_pixel, input ready);
	modport sink(input valid, sprite_pixel, dest_pixel, output ready);
endinterface

@@ sv/sam_out_if.sv @@
// Output channel carrying one merged destination pixel.
// Depends on sam_pkg.
interface sam_out_if;
	import sam_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] merged_pixel;
	logic             pixel_changed;

	modport source(output valid, merged_pixel, pixel_changed, input ready);
	modport sink(input valid, merged_pixel, pixel_changed, output ready);
endinterface

@@ sv/sprite_alpha_merge_pixel_top.sv @@
// Each accepted item is held in the input register; its merged result is then registered into the result register.
// Throughput: one item per cycle while merged.ready stays high; a stall holds the result stage and a full input stage.
// The merge datapath is one pass of unpack, 8x8 and 8x9 multiply-add, copy/blend/keep select and repack.
// Reset clears both stage valids and restores the default ARGB channel layout.
// Depends on sam_pkg, sam_in_if, sam_out_if, sam_cfg, sam_merge and the macro header.
module sprite_alpha_merge_pixel_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sam_pkg::ADDR_W-1:0]   paddr,
	input  logic [sam_pkg::DATA_W-1:0]   pwdata,
	output logic [sam_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	sam_in_if.sink                       pixel,
	sam_out_if.source                    merged
);
	import sam_pkg::*;
	`include "sprite_alpha_merge_pixel_top_macros.svh"

	sam_cfg_t         cfg;
	logic             valid_s1;
	logic [PIX_W-1:0] sprite_s1;
	logic [PIX_W-1:0] dest_s1;
	logic             valid_s2;
	logic [PIX_W-1:0] merged_s2;
	logic             changed_s2;
	logic [PIX_W-1:0] merged_c;
	logic             changed_c;
	logic             adv_s2;
	logic             take_in;

	sam_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sam_merge u_merge (
		.cfg           (cfg),
		.sprite_pixel  (sprite_s1),
		.dest_pixel    (dest_s1),
		.merged_pixel  (merged_c),
		.pixel_changed (changed_c)
	);

	assign adv_s2      = !valid_s2 || merged.ready;
	assign pixel.ready = !valid_s1 || adv_s2;
	assign take_in     = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixel.ready) begin
				valid_s1 <= pixel.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			sprite_s1 <= pixel.sprite_pixel;
			dest_s1   <= pixel.dest_pixel;
		end
		if (adv_s2 && valid_s1) begin
			merged_s2  <= merged_c;
			changed_s2 <= changed_c;
		end
	end

	assign merged.valid         = valid_s2;
	assign merged.merged_pixel  = merged_s2;
	assign merged.pixel_changed = changed_s2;

	`SAM_ASSERT_NEXT(a_accept_fills_s1, take_in, valid_s1)
	`SAM_ASSERT_NOW(a_empty_s1_ready, !valid_s1, pixel.ready)
	`SAM_ASSERT_NOW(a_full_stall_blocks, valid_s1 && valid_s2 && !merged.ready, !pixel.ready)
	`SAM_ASSERT_NEXT(a_s1_moves_to_s2, valid_s1 && adv_s2, valid_s2)
endmodule

@@ sv/sam_cfg.sv @@
// APB register file holding the eight channel shift registers.
// Depends on sam_pkg.
module sam_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sam_pkg::ADDR_W-1:0]   paddr,
	input  logic [sam_pkg::DATA_W-1:0]   pwdata,
	output logic [sam_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output sam_pkg::sam_cfg_t            cfg
);
	import sam_pkg::*;

	sam_cfg_t           cfg_q;
	logic [2:0]         reg_idx;
	logic               wr_en;
	logic [SHIFT_W-1:0] rd_val;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_red   <= RST_RED;
			cfg_q.src_green <= RST_GREEN;
			cfg_q.src_blue  <= RST_BLUE;
			cfg_q.src_alpha <= RST_ALPHA;
			cfg_q.dst_red   <= RST_RED;
			cfg_q.dst_green <= RST_GREEN;
			cfg_q.dst_blue  <= RST_BLUE;
			cfg_q.dst_alpha <= RST_ALPHA;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SRC_RED:   cfg_q.src_red   <= pwdata[SHIFT_W-1:0];
				REG_SRC_GREEN: cfg_q.src_green <= pwdata[SHIFT_W-1:0];
				REG_SRC_BLUE:  cfg_q.src_blue  <= pwdata[SHIFT_W-1:0];
				REG_SRC_ALPHA: cfg_q.src_alpha <= pwdata[SHIFT_W-1:0];
				REG_DST_RED:   cfg_q.dst_red   <= pwdata[SHIFT_W-1:0];
				REG_DST_GREEN: cfg_q.dst_green <= pwdata[SHIFT_W-1:0];
				REG_DST_BLUE:  cfg_q.dst_blue  <= pwdata[SHIFT_W-1:0];
				REG_DST_ALPHA: cfg_q.dst_alpha <= pwdata[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SRC_RED:   rd_val = cfg_q.src_red;
			REG_SRC_GREEN: rd_val = cfg_q.src_green;
			REG_SRC_BLUE:  rd_val = cfg_q.src_blue;
			REG_SRC_ALPHA: rd_val = cfg_q.src_alpha;
			REG_DST_RED:   rd_val = cfg_q.dst_red;
			REG_DST_GREEN: rd_val = cfg_q.dst_green;
			REG_DST_BLUE:  rd_val = cfg_q.dst_blue;
			REG_DST_ALPHA: rd_val = cfg_q.dst_alpha;
			default:       rd_val = '0;
		endcase
	end

	assign prdata = {{(DATA_W-SHIFT_W){1'b0}}, rd_val};
endmodule

@@ sv/sam_merge.sv @@
// Merge datapath: channel unpack, copy/blend/keep select, channel repack.
// Depends on sam_pkg.
module sam_merge (
	input  sam_pkg::sam_cfg_t           cfg,
	input  logic [sam_pkg::PIX_W-1:0]   sprite_pixel,
	input  logic [sam_pkg::PIX_W-1:0]   dest_pixel,
	output logic [sam_pkg::PIX_W-1:0]   merged_pixel,
	output logic                        pixel_changed
);
	import sam_pkg::*;

	function automatic logic [CHAN_W-1:0] chan_get(input logic [PIX_W-1:0] word,
			input logic [SHIFT_W-1:0] sh);
		logic [PIX_W-1:0] tmp;
		tmp = word >> sh;
		return tmp[CHAN_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] chan_put(input logic [CHAN_W-1:0] b,
			input logic [SHIFT_W-1:0] sh);
		logic [PIX_W-1:0] tmp;
		tmp = {{(PIX_W-CHAN_W){1'b0}}, b};
		return tmp << sh;
	endfunction

	// (d*(255-a) + s*(a+1)) >> 8
	function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] d,
			input logic [CHAN_W-1:0] s, input logic [CHAN_W-1:0] a);
		logic [CHAN_W:0]     wa;
		logic [CHAN_W-1:0]   wd;
		logic [2*CHAN_W:0]   sum;
		wa  = {1'b0, a} + 9'd1;
		wd  = ALPHA_OPAQUE - a;
		sum = ({{(CHAN_W+1){1'b0}}, d} * {{(CHAN_W+1){1'b0}}, wd})
			+ ({{(CHAN_W+1){1'b0}}, s} * {{CHAN_W{1'b0}}, wa});
		return sum[2*CHAN_W-1:CHAN_W];
	endfunction

	logic [CHAN_W-1:0] sa;
	logic [CHAN_W-1:0] da;
	logic [CHAN_W-1:0] r;
	logic [CHAN_W-1:0] g;
	logic [CHAN_W-1:0] b;
	logic [CHAN_W-1:0] na;
	logic [PIX_W-1:0]  blended;

	assign sa = chan_get(sprite_pixel, cfg.src_alpha);
	assign da = chan_get(dest_pixel, cfg.dst_alpha);
	assign r  = mix(chan_get(dest_pixel, cfg.dst_red),
		chan_get(sprite_pixel, cfg.src_red), sa);
	assign g  = mix(chan_get(dest_pixel, cfg.dst_green),
		chan_get(sprite_pixel, cfg.src_green), sa);
	assign b  = mix(chan_get(dest_pixel, cfg.dst_blue),
		chan_get(sprite_pixel, cfg.src_blue), sa);
	assign na = (sa > da) ? sa : da;

	assign blended = chan_put(r, cfg.dst_red) | chan_put(g, cfg.dst_green) |
		chan_put(b, cfg.dst_blue) | chan_put(na, cfg.dst_alpha);

	always_comb begin
		if (sa == ALPHA_OPAQUE || (da == ALPHA_CLEAR && sa != ALPHA_CLEAR)) begin
			merged_pixel  = sprite_pixel;
			pixel_changed = 1'b1;
		end else if (sa != ALPHA_CLEAR) begin
			merged_pixel  = blended;
			pixel_changed = 1'b1;
		end else begin
			merged_pixel  = dest_pixel;
			pixel_changed = 1'b0;
		end
	end
endmodule
